// ===== hw/rtl/tglr_pkg.sv =====
// tglr_pkg: shared constants and types for the glyph line renderer
// no dependencies; used by tglr_line_emit, text_glyph_line_renderer_core and tglr_checker
package tglr_pkg;

  localparam int GLYPH_WIDTH    = 17;
  localparam int GLYPH_HEIGHT   = 24;
  localparam int SCREEN_WIDTH   = 800;
  localparam int SCREEN_HEIGHT  = 480;
  localparam int GLYPH_COUNT    = 95;
  localparam int MAX_START_LINE = 19;

  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LINE_W      = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  localparam int WORD_W   = 24;
  localparam int MASK_W   = 17;
  localparam int POS_X_W  = 10;
  localparam int POS_Y_W  = 9;
  localparam int MODE_W   = 2;
  localparam int CODE_W   = 8;
  localparam int SLINE_W  = 8;
  localparam int FINDEX_W = 12;
  localparam int COLOR_W  = 32;
  localparam int CFG_IDX_W = 1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_FONT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'b1;

  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_FIRST   = 8'h20;
  localparam logic [CODE_W-1:0] CODE_LAST    = 8'h7E;

  localparam logic [COLOR_W-1:0] FG_COLOR_RST = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST = 32'hFF00_0000;

  // one glyph to draw
  typedef struct packed {
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [ADDR_W-1:0]  base;
  } glyph_job_t;

endpackage

// ===== hw/rtl/tglr_font_ram.sv =====
// tglr_font_ram: generic single write port, single read port synchronous ram
// read data registered, holds while no read is issued; no dependencies
module tglr_font_ram #(
  parameter int DEPTH  = 2280,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/tglr_line_emit.sv =====
// tglr_line_emit: walks the lines of one glyph, reads the font ram one line
// a cycle while the result register is not stalled and drives it; uses tglr_pkg
module tglr_line_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  tglr_pkg::glyph_job_t         job,
  output logic                         rd_en,
  output logic [tglr_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [tglr_pkg::WORD_W-1:0]  rd_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tglr_pkg::POS_X_W-1:0] out_pos_x,
  output logic [tglr_pkg::POS_Y_W-1:0] out_pos_y,
  output logic [tglr_pkg::MASK_W-1:0]  out_line_mask,
  output logic                         out_last_line
);

  localparam int AW = tglr_pkg::ADDR_W;
  localparam int LW = tglr_pkg::LINE_W;

  logic                 active_r;
  logic [LW-1:0]        line_r;
  tglr_pkg::glyph_job_t job_r;

  // read stage: ram data belongs to this line
  logic                          pend_r;
  logic [tglr_pkg::POS_X_W-1:0]  pend_x_r;
  logic [tglr_pkg::POS_Y_W-1:0]  pend_y_r;
  logic                          pend_last_r;
  logic                          pend_oob_r;

  logic                          out_valid_r;
  logic [tglr_pkg::POS_X_W-1:0]  out_x_r;
  logic [tglr_pkg::POS_Y_W-1:0]  out_y_r;
  logic [tglr_pkg::MASK_W-1:0]   out_mask_r;
  logic                          out_last_r;

  logic          out_free;
  logic          move;
  logic          issue;
  logic          is_last;
  logic [AW:0]   addr_full;
  logic          addr_oob;
  logic [tglr_pkg::MASK_W-1:0] word_mask;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    move      = pend_r && out_free;
    // a new read only when its data has somewhere to sit
    issue     = active_r && (!pend_r || move);
    is_last   = (line_r == LW'(tglr_pkg::GLYPH_HEIGHT - 1));
    addr_full = {1'b0, job_r.base} + (AW + 1)'(line_r);
    addr_oob  = (addr_full >= (AW + 1)'(tglr_pkg::STORE_DEPTH));
    rd_en     = issue && !addr_oob;
    rd_addr   = addr_full[AW-1:0];
    job_ready = !active_r;
    word_mask = pend_oob_r ? '0
              : rd_data[tglr_pkg::WORD_W-1 -: tglr_pkg::GLYPH_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        active_r <= 1'b1;
      end else if (issue && is_last) begin
        active_r <= 1'b0;
      end
      if (issue) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r  <= job;
      line_r <= '0;
    end else if (issue) begin
      line_r <= line_r + LW'(1);
    end
    if (issue) begin
      pend_x_r    <= job_r.pos_x;
      pend_y_r    <= job_r.pos_y + tglr_pkg::POS_Y_W'(line_r);
      pend_last_r <= is_last;
      pend_oob_r  <= addr_oob;
    end
    if (move) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_mask_r <= word_mask;
      out_last_r <= pend_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_line_mask = out_mask_r;
  assign out_last_line = out_last_r;

endmodule

// ===== hw/rtl/text_glyph_line_renderer_core.sv =====
// text_glyph_line_renderer_core: top level, cursor and request decode
// uses tglr_pkg, tglr_font_ram, tglr_line_emit
//
//   channel | direction | payload                                         | handshake
//   in_     | request   | mode, char_code, start_line, font_index, word   | valid/ready
//   out_    | result    | pos_x, pos_y, line_mask, last_line              | valid/ready
//   cfg_    | write     | index, data                                     | valid/ready
//
// a printable character holds in_ready low while its glyph lines are read, one font ram read per
// glyph line; the next request goes in the cycle after the last read
// font loads, string starts, newlines and skipped codes start no line walk
// the result register lets the next request in while a line waits at out_
// synchronous active low reset; the font ram holds no reset and needs no clearing
// a stall at out_ holds the line walker and with it in_ready
module text_glyph_line_renderer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tglr_pkg::MODE_W-1:0]      in_mode,
  input  logic [tglr_pkg::CODE_W-1:0]      in_char_code,
  input  logic [tglr_pkg::SLINE_W-1:0]     in_start_line,
  input  logic [tglr_pkg::FINDEX_W-1:0]    in_font_index,
  input  logic [tglr_pkg::WORD_W-1:0]      in_font_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tglr_pkg::POS_X_W-1:0]     out_pos_x,
  output logic [tglr_pkg::POS_Y_W-1:0]     out_pos_y,
  output logic [tglr_pkg::MASK_W-1:0]      out_line_mask,
  output logic                             out_last_line,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tglr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tglr_pkg::COLOR_W-1:0]     cfg_data
);

  localparam int XW = tglr_pkg::POS_X_W;
  localparam int YW = tglr_pkg::POS_Y_W;
  localparam int AW = tglr_pkg::ADDR_W;
  localparam int EW = 11;

  logic [XW-1:0] cursor_x_r, cursor_x_nxt;
  logic [YW-1:0] cursor_y_r, cursor_y_nxt;
  logic          halted_r, halted_nxt;
  logic [tglr_pkg::COLOR_W-1:0] fg_color_r;
  logic [tglr_pkg::COLOR_W-1:0] bg_color_r;

  logic                 accept;
  logic                 is_char;
  logic                 is_newline;
  logic                 is_print;
  logic [tglr_pkg::CODE_W-1:0] glyph;
  logic [EW-1:0]        adv_x;
  logic [EW-1:0]        adv_y;
  logic [EW-1:0]        wrap_y;
  logic                 ram_wr;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [tglr_pkg::WORD_W-1:0] ram_rd_data;
  logic                 job_valid;
  logic                 job_ready;
  tglr_pkg::glyph_job_t job;

  assign accept    = in_valid && in_ready;
  assign in_ready  = job_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    is_char    = (in_mode == tglr_pkg::MODE_CHAR) && !halted_r;
    is_newline = (in_char_code == tglr_pkg::CODE_NEWLINE);
    is_print   = (in_char_code >= tglr_pkg::CODE_FIRST) &&
                 (in_char_code <= tglr_pkg::CODE_LAST);
    glyph      = in_char_code - tglr_pkg::CODE_FIRST;
    job_valid  = accept && is_char && is_print;
    job.pos_x  = cursor_x_r;
    job.pos_y  = cursor_y_r;
    job.base   = AW'(glyph) * AW'(tglr_pkg::GLYPH_HEIGHT);
    ram_wr     = accept && (in_mode == tglr_pkg::MODE_FONT) &&
                 (in_font_index < tglr_pkg::FINDEX_W'(tglr_pkg::STORE_DEPTH));

    // cursor advance then right and bottom edge checks
    adv_x  = is_newline ? '0 : EW'(cursor_x_r) + EW'(tglr_pkg::GLYPH_WIDTH);
    adv_y  = is_newline ? EW'(cursor_y_r) + EW'(tglr_pkg::GLYPH_HEIGHT)
                        : EW'(cursor_y_r);
    wrap_y = adv_y;
    if (adv_x + EW'(tglr_pkg::GLYPH_WIDTH) > EW'(tglr_pkg::SCREEN_WIDTH)) begin
      wrap_y = adv_y + EW'(tglr_pkg::GLYPH_HEIGHT);
      adv_x  = '0;
    end

    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    halted_nxt   = halted_r;
    if (accept) begin
      if (in_mode == tglr_pkg::MODE_START) begin
        if (in_start_line > tglr_pkg::SLINE_W'(tglr_pkg::MAX_START_LINE)) begin
          halted_nxt = 1'b1;
        end else begin
          halted_nxt   = 1'b0;
          cursor_x_nxt = '0;
          cursor_y_nxt = YW'(in_start_line) * YW'(tglr_pkg::GLYPH_HEIGHT);
        end
      end else if (is_char && (is_newline || is_print)) begin
        cursor_x_nxt = adv_x[XW-1:0];
        cursor_y_nxt = wrap_y[YW-1:0];
        if (wrap_y + EW'(tglr_pkg::GLYPH_HEIGHT) > EW'(tglr_pkg::SCREEN_HEIGHT)) begin
          halted_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      halted_r   <= 1'b1;
      fg_color_r <= tglr_pkg::FG_COLOR_RST;
      bg_color_r <= tglr_pkg::BG_COLOR_RST;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      halted_r   <= halted_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tglr_pkg::CFG_FG_COLOR: fg_color_r <= cfg_data;
          tglr_pkg::CFG_BG_COLOR: bg_color_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  tglr_font_ram #(
    .DEPTH  (tglr_pkg::STORE_DEPTH),
    .WIDTH  (tglr_pkg::WORD_W),
    .ADDR_W (AW)
  ) u_font_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (in_font_index[AW-1:0]),
    .wr_data (in_font_word),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tglr_line_emit u_line_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .rd_en         (ram_rd_en),
    .rd_addr       (ram_rd_addr),
    .rd_data       (ram_rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_line_mask (out_line_mask),
    .out_last_line (out_last_line)
  );

endmodule

// ===== hw/rtl/tglr_checker.sv =====
// tglr_checker: port level checks on the result channel of the renderer
// uses tglr_pkg; bound to text_glyph_line_renderer_core
module tglr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tglr_pkg::POS_X_W-1:0]     out_pos_x,
  input logic [tglr_pkg::POS_Y_W-1:0]     out_pos_y,
  input logic [tglr_pkg::MASK_W-1:0]      out_line_mask,
  input logic                             out_last_line
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) &&
      $stable(out_pos_y) && $stable(out_line_mask) && $stable(out_last_line))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every line lands on the screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pos_x < tglr_pkg::POS_X_W'(tglr_pkg::SCREEN_WIDTH)) &&
      (out_pos_y < tglr_pkg::POS_Y_W'(tglr_pkg::SCREEN_HEIGHT)))
    else $error("glyph line off screen");

  // within a glyph, the line right after a non-final line is the row below
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_line ##1 out_valid |->
      out_pos_y == $past(out_pos_y) + tglr_pkg::POS_Y_W'(1))
    else $error("glyph lines out of order");

endmodule

bind text_glyph_line_renderer_core tglr_checker u_tglr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pos_x     (out_pos_x),
  .out_pos_y     (out_pos_y),
  .out_line_mask (out_line_mask),
  .out_last_line (out_last_line)
);
